[rtl/glae_pkg.sv]
// Package for the gamepad LED animation engine: payload types, state type, codes and constants.
`default_nettype none
package glae_pkg;

  // Animation codes
  localparam logic [7:0] AnimOff       = 8'd0;
  localparam logic [7:0] AnimAllBlink  = 8'd1;
  localparam logic [7:0] AnimFlash1    = 8'd2;
  localparam logic [7:0] AnimFlash4    = 8'd5;
  localparam logic [7:0] AnimOn1       = 8'd6;
  localparam logic [7:0] AnimOn4       = 8'd9;
  localparam logic [7:0] AnimRotate    = 8'd10;
  localparam logic [7:0] AnimBlink     = 8'd11;
  localparam logic [7:0] AnimSlowBlink = 8'd12;
  localparam logic [7:0] AnimAlternate = 8'd13;

  // Report header that selects an LED report
  localparam logic [7:0] MsgTypeLed = 8'd1;
  localparam logic [7:0] MsgLenLed  = 8'd3;

  // Input mode codes
  localparam logic ModeTick   = 1'b0;
  localparam logic ModeReport = 1'b1;

  // Elapsed counter width, then timing constants in microseconds
  localparam int unsigned ElapsedW     = 25;
  localparam int unsigned Period600    = 600000;
  localparam int unsigned Period1M     = 1000000;
  localparam int unsigned Period400    = 400000;
  localparam int unsigned OnTime       = 300000;
  localparam int unsigned RotStep      = 100000;
  localparam int unsigned FlashHold    = 1800000;
  localparam int unsigned BlinkEnd     = 4 * Period600;
  localparam int unsigned SlowBlinkEnd = 16 * Period1M;
  localparam int unsigned AltEnd       = 7 * Period600;

  localparam logic [ElapsedW-1:0] ElapsedMax = {ElapsedW{1'b1}};

  // Phase values once the elapsed counter has saturated
  localparam logic [19:0] Ph600Sat = 20'((2**ElapsedW - 1) % Period600);
  localparam logic [19:0] Ph1mSat  = 20'((2**ElapsedW - 1) % Period1M);
  localparam logic [18:0] Ph400Sat = 19'((2**ElapsedW - 1) % Period400);

  typedef struct packed {
    logic       mode;
    logic [15:0] elapsed_us;
    logic [7:0] msg_type;
    logic [7:0] msg_len;
    logic [7:0] anim_code;
  } glae_in_t;

  typedef struct packed {
    logic [3:0] led_bits;
    logic [7:0] current_anim;
    logic       player_known;
    logic [1:0] player_number;
  } glae_out_t;

  // Engine state; the phase fields track elapsed modulo each period
  typedef struct packed {
    logic [7:0]          active_anim;
    logic [7:0]          saved_anim;
    logic [ElapsedW-1:0] elapsed;
    logic [19:0]         ph600;
    logic [19:0]         ph1m;
    logic [18:0]         ph400;
    logic [3:0]          led;
    logic                player_seen;
    logic [1:0]          player_idx;
  } glae_state_t;

  localparam glae_state_t StateReset = '0;

endpackage
`default_nettype wire

[rtl/glae_step.sv]
// Next-state logic of the LED animation engine for one input item.
`default_nettype none
module glae_step (
  input  var glae_pkg::glae_state_t cur,
  input  var glae_pkg::glae_in_t    item,
  output glae_pkg::glae_state_t     nxt
);
  import glae_pkg::*;

  logic [ElapsedW:0]   sum;
  logic [ElapsedW-1:0] dt;
  logic                sat;
  logic [20:0]         p600_sum;
  logic [20:0]         p1m_sum;
  logic [19:0]         p400_sum;
  logic [19:0]         ph600;
  logic [19:0]         ph1m;
  logic [18:0]         ph400;
  logic                blink_on;
  logic                lit;
  logic [1:0]          rot_idx;
  logic                cur_temp;
  logic                detect;

  // Saturating elapsed counter
  assign sum = {1'b0, cur.elapsed} + {{(ElapsedW - 15){1'b0}}, item.elapsed_us};
  assign sat = sum[ElapsedW];
  assign dt  = sat ? ElapsedMax : sum[ElapsedW-1:0];

  // Running phases: a tick is shorter than any period, so one wrap at most
  assign p600_sum = {1'b0, cur.ph600} + {5'b0, item.elapsed_us};
  assign p1m_sum  = {1'b0, cur.ph1m} + {5'b0, item.elapsed_us};
  assign p400_sum = {1'b0, cur.ph400} + {4'b0, item.elapsed_us};

  always_comb begin
    if (sat) begin
      ph600 = Ph600Sat;
      ph1m  = Ph1mSat;
      ph400 = Ph400Sat;
    end else begin
      ph600 = (p600_sum >= Period600) ? 20'(p600_sum - Period600) : p600_sum[19:0];
      ph1m  = (p1m_sum >= Period1M) ? 20'(p1m_sum - Period1M) : p1m_sum[19:0];
      ph400 = (p400_sum >= Period400) ? 19'(p400_sum - Period400) : p400_sum[18:0];
    end
  end

  // Phase decodes
  assign blink_on = ph600 < OnTime;
  assign lit      = (dt > FlashHold) || blink_on;

  always_comb begin
    if (ph400 < RotStep)          rot_idx = 2'd0;
    else if (ph400 < 2 * RotStep) rot_idx = 2'd1;
    else if (ph400 < 3 * RotStep) rot_idx = 2'd2;
    else                          rot_idx = 2'd3;
  end

  assign cur_temp = (cur.active_anim == AnimBlink) || (cur.active_anim == AnimSlowBlink) ||
                    (cur.active_anim == AnimAlternate);

  // Flash N followed by On N assigns the player
  assign detect = !cur.player_seen && (item.anim_code >= AnimOn1) &&
                  (item.anim_code <= AnimOn4) &&
                  (cur.active_anim == 8'(item.anim_code - (AnimOn1 - AnimFlash1)));

  always_comb begin
    nxt = cur;
    if (item.mode == ModeTick) begin
      nxt.elapsed = dt;
      nxt.ph600   = ph600;
      nxt.ph1m    = ph1m;
      nxt.ph400   = ph400;
      case (cur.active_anim) inside
        AnimOff:      nxt.led = 4'h0;
        AnimAllBlink: nxt.led = blink_on ? 4'hF : 4'h0;
        [AnimFlash1:AnimFlash4]:
          nxt.led = lit ? (4'b0001 << 2'(cur.active_anim - AnimFlash1)) : 4'h0;
        [AnimOn1:AnimOn4]:
          nxt.led = 4'b0001 << 2'(cur.active_anim - AnimOn1);
        AnimRotate:   nxt.led = 4'b0001 << rot_idx;
        AnimBlink: begin
          if (dt > BlinkEnd) begin
            nxt.active_anim = cur.saved_anim;
            nxt.elapsed = '0;
            nxt.ph600 = '0;
            nxt.ph1m  = '0;
            nxt.ph400 = '0;
          end else begin
            nxt.led = blink_on ? 4'hF : 4'h0;
          end
        end
        AnimSlowBlink: begin
          if (dt > SlowBlinkEnd) begin
            nxt.active_anim = cur.saved_anim;
            nxt.elapsed = '0;
            nxt.ph600 = '0;
            nxt.ph1m  = '0;
            nxt.ph400 = '0;
          end else begin
            nxt.led = (ph1m < OnTime) ? 4'hF : 4'h0;
          end
        end
        AnimAlternate: begin
          if (dt > AltEnd) begin
            nxt.active_anim = cur.saved_anim;
            nxt.elapsed = '0;
            nxt.ph600 = '0;
            nxt.ph1m  = '0;
            nxt.ph400 = '0;
          end else begin
            nxt.led = blink_on ? 4'h9 : 4'h6;
          end
        end
        default: nxt.led = cur.led;  // unknown code: hold LEDs
      endcase
    end else if (item.msg_type == MsgTypeLed && item.msg_len == MsgLenLed) begin
      // Start a new animation
      if (detect) begin
        nxt.player_seen = 1'b1;
        nxt.player_idx  = 2'(item.anim_code - AnimOn1);
      end
      if (!cur_temp) nxt.saved_anim = cur.active_anim;
      nxt.active_anim = item.anim_code;
      nxt.elapsed = '0;
      nxt.ph600 = '0;
      nxt.ph1m  = '0;
      nxt.ph400 = '0;
    end
  end

endmodule
`default_nettype wire

[rtl/gamepad_led_animation_engine.sv]
// Top level of the gamepad LED animation engine: input register, state and result register.
//
// Usage:
//   The input channel (in_valid/in_ready/in_data) carries either a time tick
//   (mode 0, elapsed_us) or a host report (mode 1, type/length/code bytes).
//   Every accepted item yields exactly one result on the output channel
//   (out_valid/out_ready/out_data): LED bits, animation in effect and the
//   detected player, all as they stand after that item.
//   The input register loads at the input transfer edge; the result register
//   loads from it at an edge where it is empty or its result is being taken,
//   and out_valid rises with it. Throughput is one item per cycle while the
//   receiver does not stall; the update is a single pass of adds and
//   compares on running phase counters, one per blink period.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more item; in_ready then drops until the
//   result is taken.
//   Reset (rst_n low, synchronous) empties both registers, lights no LED,
//   selects animation 0 and forgets the player.
`default_nettype none
module gamepad_led_animation_engine (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  var glae_pkg::glae_in_t in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output glae_pkg::glae_out_t   out_data
);
  import glae_pkg::*;

  logic        s1_vld_r;
  glae_in_t    s1_r;
  logic        out_vld_r;
  glae_out_t   out_r;
  glae_state_t state_r;
  glae_state_t state_nxt;
  logic        advance;

  // Pipeline flow control
  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !s1_vld_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_r <= in_data;
    end
  end

  glae_step u_step (
    .cur  (state_r),
    .item (s1_r),
    .nxt  (state_nxt)
  );

  // Engine state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= StateReset;
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= s1_vld_r;
      if (s1_vld_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_vld_r) begin
      out_r.led_bits      <= state_nxt.led;
      out_r.current_anim  <= state_nxt.active_anim;
      out_r.player_known  <= state_nxt.player_seen;
      out_r.player_number <= state_nxt.player_idx;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

[rtl/glae_checker.sv]
// Port-level checker for the gamepad LED animation engine and its bind.
`default_nettype none
module glae_checker (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    in_ready,
  input wire                    out_valid,
  input wire                    out_ready,
  input var glae_pkg::glae_out_t out_data
);
  import glae_pkg::*;

  logic       known_r;
  logic [1:0] number_r;

  // Remember the first player reported on a result transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r  <= 1'b0;
      number_r <= 2'd0;
    end else if (out_valid && out_ready && out_data.player_known && !known_r) begin
      known_r  <= 1'b1;
      number_r <= out_data.player_number;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // With no result pending the input side is always open
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Once assigned, the player stays the same
  a_player_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && known_r |-> out_data.player_known && out_data.player_number == number_r)
    else $error("player assignment changed");

  // No player index before a player is known
  a_player_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.player_known |-> out_data.player_number == 2'd0)
    else $error("player index set without a player");

endmodule

bind gamepad_led_animation_engine glae_checker u_glae_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

[dv/gamepad_led_animation_engine_checker.sv]
// Checker for the gamepad LED animation engine: predicts every result and compares it.
module gamepad_led_animation_engine_checker (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_ready,
  input  glae_pkg::glae_in_t  in_data,
  input  wire                 out_valid,
  input  wire                 out_ready,
  input  glae_pkg::glae_out_t out_data,
  output int unsigned         mismatches,
  output int unsigned         awaiting,
  output int unsigned         checked
);
  import glae_pkg::*;

  // Predicted engine state
  logic [7:0]  lamp_anim;
  logic [7:0]  lamp_saved;
  int unsigned lamp_time;
  logic [3:0]  lamp_bits;
  logic        player_found;
  logic [1:0]  player_slot;

  // Status words still owed by the block, oldest first
  glae_out_t   pending_status[$];

  initial begin
    mismatches = 0;
    awaiting   = 0;
    checked    = 0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH result %0d %s: got 0x%0h, want 0x%0h", checked, what, got, want);
    mismatches++;
  endtask

  // Apply one item to the predicted state and queue the status it yields
  task automatic advance_lamps(input glae_in_t it);
    int unsigned t;
    logic        lit;
    glae_out_t   status;
    if (it.mode == ModeTick) begin
      t = lamp_time + it.elapsed_us;
      if (t > ElapsedMax) t = ElapsedMax;
      lamp_time = t;
      if (lamp_anim == AnimOff) begin
        lamp_bits = 4'h0;
      end else if (lamp_anim == AnimAllBlink) begin
        lamp_bits = ((t % Period600) < OnTime) ? 4'hF : 4'h0;
      end else if (lamp_anim >= AnimFlash1 && lamp_anim <= AnimFlash4) begin
        lit = (t > FlashHold) || ((t % Period600) < OnTime);
        lamp_bits = lit ? 4'b0001 << (lamp_anim - AnimFlash1) : 4'h0;
      end else if (lamp_anim >= AnimOn1 && lamp_anim <= AnimOn4) begin
        lamp_bits = 4'b0001 << (lamp_anim - AnimOn1);
      end else if (lamp_anim == AnimRotate) begin
        lamp_bits = 4'b0001 << ((t % Period400) / RotStep);
      end else if (lamp_anim == AnimBlink) begin
        if (t > BlinkEnd) begin
          lamp_anim = lamp_saved;
          lamp_time = 0;
        end else begin
          lamp_bits = ((t % Period600) < OnTime) ? 4'hF : 4'h0;
        end
      end else if (lamp_anim == AnimSlowBlink) begin
        if (t > SlowBlinkEnd) begin
          lamp_anim = lamp_saved;
          lamp_time = 0;
        end else begin
          lamp_bits = ((t % Period1M) < OnTime) ? 4'hF : 4'h0;
        end
      end else if (lamp_anim == AnimAlternate) begin
        if (t > AltEnd) begin
          lamp_anim = lamp_saved;
          lamp_time = 0;
        end else begin
          lamp_bits = ((t % Period600) < OnTime) ? 4'h9 : 4'h6;
        end
      end
      // unknown codes leave the LEDs as they are
    end else if (it.msg_type == MsgTypeLed && it.msg_len == MsgLenLed) begin
      // first Flash N followed by On N names the player
      if (!player_found && it.anim_code >= AnimOn1 && it.anim_code <= AnimOn4 &&
          lamp_anim == it.anim_code - (AnimOn1 - AnimFlash1)) begin
        player_found = 1'b1;
        player_slot  = 2'(it.anim_code - AnimOn1);
      end
      // a temporary animation never becomes the one to return to
      if (!(lamp_anim == AnimBlink || lamp_anim == AnimSlowBlink ||
            lamp_anim == AnimAlternate))
        lamp_saved = lamp_anim;
      lamp_anim = it.anim_code;
      lamp_time = 0;
    end
    status.led_bits      = lamp_bits;
    status.current_anim  = lamp_anim;
    status.player_known  = player_found;
    status.player_number = player_slot;
    pending_status.push_back(status);
  endtask

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    glae_out_t want;
    if (!rst_n) begin
      lamp_anim    = AnimOff;
      lamp_saved   = AnimOff;
      lamp_time    = 0;
      lamp_bits    = 4'h0;
      player_found = 1'b0;
      player_slot  = 2'd0;
      pending_status.delete();
    end else begin
      if (in_valid && in_ready) advance_lamps(in_data);
      if (out_valid && out_ready) begin
        if (pending_status.size() == 0) begin
          report_mismatch("transfer with no result pending", out_data, 0);
        end else begin
          want = pending_status.pop_front();
          if (out_data.led_bits != want.led_bits)
            report_mismatch("led_bits", out_data.led_bits, want.led_bits);
          if (out_data.current_anim != want.current_anim)
            report_mismatch("current_anim", out_data.current_anim, want.current_anim);
          if (out_data.player_known != want.player_known)
            report_mismatch("player_known", out_data.player_known, want.player_known);
          if (out_data.player_number != want.player_number)
            report_mismatch("player_number", out_data.player_number, want.player_number);
        end
        checked++;
      end
    end
    awaiting <= pending_status.size();
  end

endmodule

[dv/gamepad_led_animation_engine_test.sv]
// Testbench top for the gamepad LED animation engine: clock, reset, stimulus and verdict.
module gamepad_led_animation_engine_test;
  import glae_pkg::*;

  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned HoldOff   = 300;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  glae_in_t  in_data   = '0;
  logic      out_ready = 1'b0;
  wire       in_ready;
  wire       out_valid;
  glae_out_t out_data;

  int unsigned mismatches;
  int unsigned awaiting;
  int unsigned checked;

  int unsigned sent       = 0;
  int unsigned n_ticks    = 0;
  int unsigned n_led      = 0;
  int unsigned n_other    = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  bit          sat_done   = 1'b0;
  bit          hold_done  = 1'b0;

  always #6 clk = ~clk;

  gamepad_led_animation_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  gamepad_led_animation_engine_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .awaiting   (awaiting),
    .checked    (checked)
  );

  function automatic glae_in_t raw_item(input logic mode, input logic [15:0] us,
                                        input logic [7:0] typ, input logic [7:0] len,
                                        input logic [7:0] code);
    glae_in_t it;
    it.mode       = mode;
    it.elapsed_us = us;
    it.msg_type   = typ;
    it.msg_len    = len;
    it.anim_code  = code;
    return it;
  endfunction

  // Unused fields carry random junk
  function automatic glae_in_t tick_item(input logic [15:0] us);
    return raw_item(ModeTick, us, 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic glae_in_t led_report(input logic [7:0] code);
    return raw_item(ModeReport, 16'($urandom), MsgTypeLed, MsgLenLed, code);
  endfunction

  // One input transfer; the sender idles between bursts
  task automatic send_item(input glae_in_t it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 200)
                                                : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
    sent++;
    if (it.mode == ModeTick) n_ticks++;
    else if (it.msg_type == MsgTypeLed && it.msg_len == MsgLenLed) n_led++;
    else n_other++;
  endtask

  // Ticks of at least lo microseconds, with the extremes mixed in
  task automatic run_ticks(input int unsigned n, input int unsigned lo);
    logic [15:0] us;
    repeat (n) begin
      case ($urandom_range(0, 7))
        0:       us = (lo == 0) ? 16'd0 : 16'hFFFF;
        1:       us = 16'hFFFF;
        default: us = 16'($urandom_range(lo, 65535));
      endcase
      send_item(tick_item(us));
    end
  endtask

  // Stimulus
  initial begin
    logic [7:0]  code;
    glae_in_t    it;
    int unsigned pick;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every code family, bad headers, player four
    send_item(raw_item(ModeTick, 16'd0, 8'hFF, 8'hFF, 8'hFF));
    send_item(tick_item(16'hFFFF));
    send_item(led_report(AnimAllBlink));
    send_item(tick_item(16'hFFFF));
    send_item(led_report(AnimFlash1));
    send_item(tick_item(16'd0));
    send_item(led_report(AnimOn1 + 8'd1));        // On 2 after Flash 1: no player
    send_item(led_report(AnimFlash4));
    send_item(led_report(AnimOn4));               // player four
    send_item(tick_item(16'hFFFF));
    send_item(led_report(AnimRotate));
    send_item(tick_item(16'hFFFF));
    send_item(led_report(AnimBlink));
    send_item(tick_item(16'd1));
    send_item(led_report(AnimAlternate));         // temporary over temporary
    send_item(tick_item(16'hFFFF));
    send_item(led_report(AnimSlowBlink));
    send_item(tick_item(16'h8000));
    send_item(led_report(8'd14));
    send_item(tick_item(16'hFFFF));               // unknown code holds LEDs
    send_item(led_report(8'hFF));
    send_item(raw_item(ModeReport, 16'hFFFF, MsgTypeLed, 8'd2, AnimOff));
    send_item(raw_item(ModeReport, 16'h0000, 8'd0, MsgLenLed, AnimOff));
    send_item(raw_item(ModeReport, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(raw_item(ModeTick, 16'hFFFF, MsgTypeLed, MsgLenLed, AnimOff));
    send_item(led_report(AnimOff));
    send_item(tick_item(16'd0));

    // Random sequences, mostly well-formed animation runs
    while (sent < 700) begin
      if (!sat_done && sent >= 60) begin
        // hold a phase animation long enough to saturate the elapsed counter
        sat_done = 1'b1;
        send_item(led_report($urandom_range(0, 1) ? AnimAllBlink : AnimRotate));
        run_ticks(560, 62000);
        run_ticks($urandom_range(1, 5), 0);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            code = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(14, 255))
                                               : 8'($urandom_range(0, 13));
            send_item(led_report(code));
            run_ticks($urandom_range(1, 25), $urandom_range(0, 1) ? 0 : 30000);
          end
          4, 5: begin
            // temporary animation played to its end
            pick = $urandom_range(0, 5);
            if (pick == 0) begin
              send_item(led_report(AnimSlowBlink));
              run_ticks(270 + $urandom_range(0, 3), 60000);
            end else if (pick < 3) begin
              send_item(led_report(AnimAlternate));
              run_ticks(72 + $urandom_range(0, 4), 60000);
            end else begin
              send_item(led_report(AnimBlink));
              run_ticks(42 + $urandom_range(0, 4), 60000);
            end
          end
          6: begin
            // stacked temporaries fall back to the base animation
            send_item(led_report(8'($urandom_range(0, 10))));
            run_ticks($urandom_range(1, 4), 0);
            send_item(led_report($urandom_range(0, 1) ? AnimAlternate : AnimSlowBlink));
            run_ticks($urandom_range(0, 5), 0);
            send_item(led_report(AnimBlink));
            run_ticks(42 + $urandom_range(0, 4), 60000);
          end
          7: begin
            // flash then on, matched or not
            code = AnimFlash1 + 8'($urandom_range(0, 3));
            send_item(led_report(code));
            run_ticks($urandom_range(0, 40), 30000);
            send_item(led_report($urandom_range(0, 1) ? code + 8'd4
                                                      : AnimOn1 + 8'($urandom_range(0, 3))));
            run_ticks($urandom_range(1, 6), 0);
          end
          8: begin
            repeat ($urandom_range(1, 6))
              send_item(raw_item(1'($urandom), 16'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom)));
          end
          default: begin
            // reports with a bad header, ticks with an LED header
            repeat ($urandom_range(1, 4)) begin
              it = led_report(8'($urandom));
              case ($urandom_range(0, 2))
                0: begin
                  it.msg_len = 8'($urandom);
                  if (it.msg_len == MsgLenLed) it.msg_len = 8'd0;
                end
                1: begin
                  it.msg_type = 8'($urandom);
                  if (it.msg_type == MsgTypeLed) it.msg_type = 8'd0;
                end
                default: it.mode = ModeTick;
              endcase
              send_item(it);
            end
          end
        endcase
      end
    end
    in_valid <= 1'b0;

    // Drain, then allow for the pipeline latency
    while (awaiting != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Summary: %0d items (%0d ticks, %0d LED reports, %0d other reports)",
             sent, n_ticks, n_led, n_other);
    $display("Summary: %0d results checked, counter saturated %0d, long stall %0d",
             checked, sat_done, hold_done);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Receiver: stall patterns, plus one long hold-off to back the block up
  initial begin
    int unsigned span;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (!hold_done && sent >= 200) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldOff) @(negedge clk);
      end
      span = $urandom_range(4, 60);
      case ($urandom_range(0, 2))
        0: repeat (span) begin
          out_ready <= 1'b1;
          @(negedge clk);
        end
        1: repeat (span) begin
          out_ready <= 1'($urandom_range(0, 1));
          @(negedge clk);
        end
        default: repeat (span) begin
          out_ready <= ($urandom_range(0, 3) == 0);
          @(negedge clk);
        end
      endcase
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IdleLimit) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
               IdleLimit, awaiting);
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
